// ===== rtl/bfrp_pkg.sv =====
// bfrp_pkg: shared types and constants for the bilateral filter block
// no dependencies
package bfrp_pkg;

   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_RANGE   = 2'd1;
   localparam logic [1:0] KIND_SPATIAL = 2'd2;
   localparam logic [1:0] KIND_DRAIN   = 2'd3;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   localparam int CSR_DATA_BITS = 12;
   localparam int PIX_MAX       = 255;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  pixel_in;
      logic [7:0]  table_index;
      logic [15:0] table_weight;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered_pixel;
      logic       frame_end;
   } rsp_type;

   // start and result between sequencer and divider
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// ===== rtl/bfrp_div.sv =====
// bfrp_div: restoring serial divider, one quotient bit per cycle
// depends on bfrp_pkg
module bfrp_div import bfrp_pkg::*; #(
   parameter int NUM_BITS = 48,
   parameter int DEN_BITS = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output div_ctl_type         ctl,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CW = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS+1:0] trial;

   // load on start, else one shift-subtract step while busy
   always_comb begin
      q_in = q_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         q_in = num; rem_in = '0; den_in = den;
         cnt_in = CW'(NUM_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, q_ff[NUM_BITS-1]} - {2'b00, den_ff};
         if (!trial[DEN_BITS+1]) begin
            rem_in = trial[DEN_BITS:0];
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quot      = q_ff;
endmodule

// ===== rtl/bilateral_filter_reflect_pad.sv =====
// bilateral_filter_reflect_pad: top level, sequencer, line store, weight tables
// depends on bfrp_pkg and bfrp_div
//
// usage
// - req channel (valid/stall) carries pixels in raster order, weight table
//   writes (range by intensity difference, spatial by window offset) and
//   drain items; a drain emits one pending output if there is one
// - rsp channel (valid/stall) gives one filtered pixel per completed window,
//   frame_end marks the last pixel of a frame
// - csr port writes frame_width, frame_height, window_radius; a write to any
//   of these restarts the stream; write only while idle
// - a table write completes while idle; a pixel or drain that completes no
//   window passes the check state and goes back to idle; an item that produces
//   a pixel walks all (2r+1)^2 taps through address, read, multiply and
//   accumulate states on the shared memory read port and multiplier, then a
//   serial divide of NUMB quotient bits (NUMB = WEIGHT_BITS + 24)
// - req_stall is high while an item is in work
// - a result held by rsp_stall sits in the output register; the next item is
//   taken, but a new result waits until that transfer is done
// - reset clears counters and control; line store and tables are not
//   cleared and read as unknown until written
module bilateral_filter_reflect_pad import bfrp_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_RADIUS  = 4,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);
   localparam int SPAN   = 2 * MAX_RADIUS + 1;
   localparam int SDEP   = SPAN * SPAN;
   localparam int SLOTB  = $clog2(SPAN);
   localparam int COLB   = $clog2(MAX_WIDTH);
   localparam int ADDRB  = $clog2(SPAN * MAX_WIDTH);
   localparam int SIB    = $clog2(SDEP);
   localparam int WB     = WEIGHT_BITS;
   localparam int DENB   = WB + 8;
   localparam int NUMB   = WB + 16 + 8;
   localparam int RB     = $clog2(MAX_RADIUS + 1);
   localparam int SLOT_RECIP = (65536 + SPAN - 1) / SPAN;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CHECK  = 9'b000000010,
      S_CENTRE = 9'b000000100,
      S_ADDR   = 9'b000001000,
      S_READ   = 9'b000010000,
      S_MUL    = 9'b000100000,
      S_ACC    = 9'b001000000,
      S_DIV    = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   // row to line store slot by reciprocal multiply, exact for rows below 4096
   function automatic logic [SLOTB-1:0] slot_of(input logic [11:0] row);
      logic [28:0] scaled;
      logic [11:0] whole;
      logic [15:0] back;
      scaled = 29'(row) * 29'(SLOT_RECIP);
      whole  = scaled[27:16];
      back   = 16'(whole) * 16'(SPAN);
      return SLOTB'(16'(row) - back);
   endfunction

   // memories
   logic [7:0]    line_mem [SPAN*MAX_WIDTH];
   logic [WB-1:0] range_mem [256];
   logic [WB-1:0] spat_mem [SDEP];
   logic [7:0]    line_rd_ff;
   logic [WB-1:0] range_rd_ff, spat_rd_ff;

   state_type     st_ff, st_in;
   req_type       item_ff, item_in;
   logic [10:0]   cw_ff, cw_in;
   logic [11:0]   ch_ff, ch_in;
   logic [2:0]    cr_ff, cr_in;
   logic [11:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COLB-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SLOTB-1:0] in_slot_ff, in_slot_in;
   logic          done_ff, done_in;
   logic signed [4:0] dy_ff, dy_in, dx_ff, dx_in;
   logic [7:0]    centre_ff, centre_in, pix_ff, pix_in;
   logic [WB-1:0] tw_ff, tw_in;
   logic [NUMB-1:0] num_ff, num_in;
   logic [DENB-1:0] den_ff, den_in;
   logic          rv_ff, rv_in;
   rsp_type       rd_ff, rd_in;

   // effective geometry
   logic [11:0] ew, eh, em;
   logic [RB-1:0] er;
   always_comb begin
      ew = {1'b0, cw_ff};
      if (ew < 12'd3) ew = 12'd3;
      if (MAX_WIDTH < 2048 && ew > 12'(MAX_WIDTH)) ew = 12'(MAX_WIDTH);
      eh = ch_ff;
      if (eh < 12'd3) eh = 12'd3;
      em = (ew < eh) ? ew : eh;
      er = (cr_ff == 3'd0) ? RB'(1) :
           ({1'b0, cr_ff} > 4'(MAX_RADIUS)) ? RB'(MAX_RADIUS) : RB'(cr_ff);
      if (13'({er, 1'b1}) > 13'(em)) er = RB'((em - 12'd1) >> 1);
   end

   // window readiness: compare linear positions
   logic [11:0] need_row, need_col, oc_ext;
   logic [23:0] need_pos, have_pos;
   logic        window_ready;
   always_comb begin
      oc_ext   = 12'(out_col_ff);
      need_row = (out_row_ff + 12'(er) < eh - 12'd1) ? out_row_ff + 12'(er) : eh - 12'd1;
      need_col = (oc_ext + 12'(er) < ew - 12'd1) ? oc_ext + 12'(er) : ew - 12'd1;
      need_pos = need_row * ew + 24'(need_col) + 24'd1;
      have_pos = in_row_ff * ew + 24'(in_col_ff);
      window_ready = done_ff || (have_pos >= need_pos);
   end

   // tap address with reflection
   logic signed [13:0] yy, xx;
   logic [11:0] yr;
   logic [11:0] xr;
   logic [SLOTB-1:0] yslot;
   logic [ADDRB-1:0] tap_addr, wr_addr;
   logic [SIB-1:0] tap_si;
   always_comb begin
      yy = $signed({2'b00, out_row_ff}) + 14'(dy_ff);
      xx = $signed({2'b00, oc_ext}) + 14'(dx_ff);
      if (yy < 0) yy = -yy;
      else if (yy >= $signed({2'b00, eh})) yy = $signed({1'b0, eh, 1'b0}) - 14'sd2 - yy;
      if (xx < 0) xx = -xx;
      else if (xx >= $signed({2'b00, ew})) xx = $signed({1'b0, ew, 1'b0}) - 14'sd2 - xx;
      yr = yy[11:0];
      xr = xx[11:0];
      yslot = slot_of(yr);
      tap_addr = ADDRB'(yslot * MAX_WIDTH + int'(xr[COLB-1:0]));
      tap_si = SIB'((int'(dy_ff) + MAX_RADIUS) * SPAN + int'(dx_ff) + MAX_RADIUS);
      wr_addr = ADDRB'(in_slot_ff * MAX_WIDTH + int'(in_col_ff));
   end

   // range index from the tap pixel as it leaves the line store
   logic [7:0] diff;
   assign diff = (line_rd_ff > centre_ff) ? line_rd_ff - centre_ff : centre_ff - line_rd_ff;

   logic [2*WB-1:0] wprod;
   assign wprod = spat_rd_ff * range_rd_ff;

   // divider
   logic div_start;
   div_ctl_type div_ctl;
   logic [NUMB-1:0] quot;
   bfrp_div #(.NUM_BITS(NUMB), .DEN_BITS(DENB)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(num_ff), .den(den_ff), .ctl(div_ctl), .quot(quot));

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != S_IDLE);

   // sequencer
   logic last;
   always_comb begin
      st_in = st_ff; item_in = item_ff;
      cw_in = cw_ff; ch_in = ch_ff; cr_in = cr_ff;
      in_row_in = in_row_ff; in_col_in = in_col_ff; in_slot_in = in_slot_ff;
      out_row_in = out_row_ff; out_col_in = out_col_ff; done_in = done_ff;
      dy_in = dy_ff; dx_in = dx_ff; centre_in = centre_ff; pix_in = pix_ff;
      tw_in = tw_ff; num_in = num_ff; den_in = den_ff;
      rv_in = rv_ff; rd_in = rd_ff; div_start = 1'b0;
      last = (out_row_ff == eh - 12'd1) && (oc_ext == ew - 12'd1);
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.kind == KIND_PIXEL && !done_ff) begin
                  if (12'(in_col_ff) + 12'd1 >= ew) begin
                     in_col_in = '0;
                     if (in_row_ff + 12'd1 >= eh) begin
                        in_row_in = '0; in_slot_in = '0; done_in = 1'b1;
                     end else begin
                        in_row_in = in_row_ff + 12'd1;
                        in_slot_in = (in_slot_ff == SLOTB'(SPAN - 1)) ? '0
                                     : in_slot_ff + 1'b1;
                     end
                  end else begin
                     in_col_in = in_col_ff + 1'b1;
                  end
               end
               if (req_data.kind == KIND_PIXEL || req_data.kind == KIND_DRAIN)
                  st_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (window_ready) begin
               dy_in = -5'(er); dx_in = -5'(er);
               num_in = '0; den_in = '0;
               st_in = S_CENTRE;
            end else begin
               st_in = S_IDLE;
            end
         end
         // centre pixel from the second read port
         S_CENTRE: begin
            centre_in = centre_rd_ff;
            st_in = S_ADDR;
         end
         S_ADDR: st_in = S_READ;
         S_READ: begin
            pix_in = line_rd_ff;
            st_in = S_MUL;
         end
         S_MUL: begin
            tw_in = wprod[2*WB-1:WB];
            st_in = S_ACC;
         end
         S_ACC: begin
            num_in = num_ff + NUMB'(tw_ff) * NUMB'(pix_ff);
            den_in = den_ff + DENB'(tw_ff);
            if (dx_ff == 5'(er)) begin
               dx_in = -5'(er);
               if (dy_ff == 5'(er)) begin
                  st_in = S_DIV;
               end else begin
                  dy_in = dy_ff + 5'sd1;
                  st_in = S_ADDR;
               end
            end else begin
               dx_in = dx_ff + 5'sd1;
               st_in = S_ADDR;
            end
         end
         // start once the sums are complete, then wait for the quotient
         S_DIV: begin
            if (div_ctl.done) st_in = S_OUT;
            else if (!div_ctl.busy) div_start = 1'b1;
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rd_in.frame_end = last;
               if (den_ff == '0) rd_in.filtered_pixel = centre_ff;
               else if (quot > NUMB'(PIX_MAX)) rd_in.filtered_pixel = 8'(PIX_MAX);
               else rd_in.filtered_pixel = quot[7:0];
               if (last) begin
                  out_row_in = '0; out_col_in = '0; done_in = 1'b0;
               end else if (oc_ext + 12'd1 >= ew) begin
                  out_col_in = '0; out_row_in = out_row_ff + 12'd1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (csr_write && csr_index <= CSR_RADIUS) begin
         if (csr_index == CSR_WIDTH) cw_in = csr_data[10:0];
         else if (csr_index == CSR_HEIGHT) ch_in = csr_data[11:0];
         else cr_in = csr_data[2:0];
         in_row_in = '0; in_col_in = '0; in_slot_in = '0;
         out_row_in = '0; out_col_in = '0; done_in = 1'b0;
      end
   end

   // memories: one write port each; one read port each for the tables, two for the line store
   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && accept && req_data.kind == KIND_PIXEL && !done_ff)
         line_mem[wr_addr] <= req_data.pixel_in;
      if (st_ff == S_IDLE && accept && req_data.kind == KIND_RANGE)
         range_mem[req_data.table_index] <= WB'(req_data.table_weight);
      if (st_ff == S_IDLE && accept && req_data.kind == KIND_SPATIAL
          && int'(req_data.table_index) < SDEP)
         spat_mem[SIB'(req_data.table_index)] <= WB'(req_data.table_weight);
      line_rd_ff  <= line_mem[tap_addr];
      range_rd_ff <= range_mem[diff];
      spat_rd_ff  <= spat_mem[tap_si];
   end

   // centre fetch at the current output position
   logic [ADDRB-1:0] centre_addr;
   logic [7:0] centre_rd_ff;
   assign centre_addr = ADDRB'(slot_of(out_row_ff) * MAX_WIDTH + int'(out_col_ff));
   always_ff @(posedge clock) begin
      centre_rd_ff <= line_mem[centre_addr];
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; dy_ff <= dy_in; dx_ff <= dx_in;
      pix_ff <= pix_in; tw_ff <= tw_in; num_ff <= num_in; den_ff <= den_in;
      rd_ff <= rd_in;
      centre_ff <= centre_in;
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0;
         cw_ff <= 11'd768; ch_ff <= 12'd512; cr_ff <= 3'd2;
         in_row_ff <= '0; in_col_ff <= '0; in_slot_ff <= '0;
         out_row_ff <= '0; out_col_ff <= '0; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in;
         cw_ff <= cw_in; ch_ff <= ch_in; cr_ff <= cr_in;
         in_row_ff <= in_row_in; in_col_ff <= in_col_in; in_slot_ff <= in_slot_in;
         out_row_ff <= out_row_in; out_col_ff <= out_col_in; done_ff <= done_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for bilateral_filter_reflect_pad
// depends on bfrp_pkg and the block's rtl; carries its own filter predictor
module testbench;
   import bfrp_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int SPAN       = 9;
   localparam int ROW_LEN    = 1024;
   localparam int TAPS       = SPAN * SPAN;
   localparam int SETTLE     = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   bilateral_filter_reflect_pad dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // filter predictor state
   logic [7:0]  line_rows [0:SPAN-1][0:ROW_LEN-1];
   logic [15:0] range_tab [0:255];
   logic [15:0] space_tab [0:TAPS-1];
   int cfg_w = 768, cfg_h = 512, cfg_r = 2;
   int in_row, in_col, out_row, out_col;
   bit in_done;

   req_type pixel_queue[$];
   rsp_type pixel_expect[$];
   int items_made, items_sent, mismatches;
   bit fast_send;

   function automatic int mirror(int i, int n);
      if (i < 0) return -i;
      if (i >= n) return 2 * (n - 1) - i;
      return i;
   endfunction

   function automatic void geometry(output int w, output int h, output int r);
      int m;
      w = (cfg_w < 3) ? 3 : (cfg_w > ROW_LEN ? ROW_LEN : cfg_w);
      h = (cfg_h < 3) ? 3 : (cfg_h > 4095 ? 4095 : cfg_h);
      r = (cfg_r < 1) ? 1 : (cfg_r > 4 ? 4 : cfg_r);
      m = (w < h) ? w : h;
      if (2 * r + 1 > m) r = (m - 1) / 2;
   endfunction

   function automatic void restart_stream();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0; in_done = 0;
   endfunction

   // one item through the filter; returns 1 when a pixel comes out
   function automatic bit filter_step(input req_type it, output rsp_type res);
      int w, h, r, need_row, need_col, yy, xx, diff;
      logic [7:0] centre, p;
      logic [31:0] wt;
      longint unsigned num, den, q;
      bit last;
      res = '0;
      if (it.kind == KIND_RANGE) begin
         range_tab[it.table_index] = it.table_weight;
         return 0;
      end
      if (it.kind == KIND_SPATIAL) begin
         if (it.table_index < TAPS) space_tab[it.table_index] = it.table_weight;
         return 0;
      end
      geometry(w, h, r);
      if (it.kind == KIND_PIXEL && !in_done) begin
         line_rows[in_row % SPAN][in_col] = it.pixel_in;
         if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row + 1 >= h) begin
               in_row = 0;
               in_done = 1;
            end else begin
               in_row++;
            end
         end else begin
            in_col++;
         end
      end
      if (!in_done) begin
         need_row = (out_row + r < h - 1) ? out_row + r : h - 1;
         need_col = (out_col + r < w - 1) ? out_col + r : w - 1;
         if (in_row * w + in_col < need_row * w + need_col + 1) return 0;
      end
      centre = line_rows[out_row % SPAN][out_col];
      num = 0;
      den = 0;
      for (int dy = -r; dy <= r; dy++) begin
         yy = mirror(out_row + dy, h);
         for (int dx = -r; dx <= r; dx++) begin
            xx = mirror(out_col + dx, w);
            p = line_rows[yy % SPAN][xx];
            diff = (p > centre) ? p - centre : centre - p;
            wt = (32'(space_tab[(dy + 4) * SPAN + dx + 4]) * 32'(range_tab[diff])) >> 16;
            num += 64'(wt) * 64'(p);
            den += 64'(wt);
         end
      end
      if (den == 0) q = centre;
      else begin
         q = num / den;
         if (q > PIX_MAX) q = PIX_MAX;
      end
      last = (out_row == h - 1) && (out_col == w - 1);
      res.filtered_pixel = q[7:0];
      res.frame_end = last;
      if (last) begin
         out_row = 0; out_col = 0; in_done = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0; out_row++;
      end else begin
         out_col++;
      end
      return 1;
   endfunction

   // queue one item and its expected pixel; returns 1 on frame end
   function automatic bit queue_item(input logic [1:0] kind, input logic [7:0] pix,
                                     input logic [7:0] idx, input logic [15:0] wgt);
      req_type it;
      rsp_type res;
      it.kind = kind;
      it.pixel_in = pix;
      it.table_index = idx;
      it.table_weight = wgt;
      pixel_queue.push_back(it);
      items_made++;
      if (filter_step(it, res)) begin
         pixel_expect.push_back(res);
         return res.frame_end;
      end
      return 0;
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (fast_send || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(40, 250);
   endfunction

   // pixels of a frame, some noise between them, then drains and pixels to the frame end
   task automatic send_frame(input int npix, input bit noisy, input bit flat);
      bit done;
      for (int i = 0; i < npix; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: done = queue_item(KIND_DRAIN, rnd8(), rnd8(), rnd16());
               1: done = queue_item(KIND_RANGE, rnd8(), rnd8(), rnd16());
               default: done = queue_item(KIND_SPATIAL, rnd8(), rnd8(), rnd16());
            endcase
         end
         done = queue_item(KIND_PIXEL, flat ? 8'd0 : (i[0] ? 8'd255 : rnd8()),
                           rnd8(), rnd16());
      end
      done = 0;
      while (!done) begin
         if ($urandom_range(0, 1)) done = queue_item(KIND_DRAIN, rnd8(), rnd8(), rnd16());
         else done = queue_item(KIND_PIXEL, rnd8(), rnd8(), rnd16());
      end
   endtask

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || items_sent != items_made || pixel_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_WIDTH: cfg_w = value & 'h7ff;
         CSR_HEIGHT: cfg_h = value & 'hfff;
         CSR_RADIUS: cfg_r = value & 'h7;
         default: return;
      endcase
      restart_stream();
   endtask

   task automatic set_geometry(input int w, input int h, input int r);
      wait_idle();
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_RADIUS, r);
   endtask

   // stimulus
   initial begin
      bit done;
      int w, h, r, ew, eh, er, total;
      restart_stream();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill both weight tables before any pixel
      for (int i = 0; i < 256; i++)
         done = queue_item(KIND_RANGE, rnd8(), 8'(i),
                           i == 0 ? 16'hffff : (i == 255 ? 16'h0000 : rnd16()));
      for (int i = 0; i < TAPS; i++)
         done = queue_item(KIND_SPATIAL, rnd8(), 8'(i), i == 40 ? 16'hffff : rnd16());
      done = queue_item(KIND_SPATIAL, rnd8(), 8'd255, rnd16());

      // smallest frame, extreme pixels, early drain
      set_geometry(3, 3, 1);
      done = queue_item(KIND_DRAIN, 8'd0, 8'd0, 16'd0);
      send_frame(9, 0, 0);
      // all taps at zero weight: centre pixel comes back
      for (int dy = 3; dy <= 5; dy++)
         for (int dx = 3; dx <= 5; dx++)
            done = queue_item(KIND_SPATIAL, rnd8(), 8'(dy * SPAN + dx), 16'd0);
      send_frame(9, 0, 0);
      for (int i = 0; i < TAPS; i++)
         done = queue_item(KIND_SPATIAL, rnd8(), 8'(i), rnd16());
      send_frame(9, 0, 1);

      // register write outside the list is ignored
      wait_idle();
      write_reg(CSR_UNUSED, $urandom_range(0, 4095));
      send_frame(9, 1, 0);

      // widest row with clamped width, radius squeezed by the height;
      // first row and the start of the second only
      set_geometry(2047, 3, 7);
      fast_send = 1;
      for (int i = 0; i < ROW_LEN + 24; i++)
         done = queue_item(KIND_PIXEL, rnd8(), rnd8(), rnd16());
      // tallest frame, only its first rows; the next write restarts it
      set_geometry(3, 4095, 0);
      for (int i = 0; i < 40; i++) done = queue_item(KIND_PIXEL, rnd8(), rnd8(), rnd16());
      fast_send = 0;

      // random frames of random small geometry
      total = 0;
      while (total < 200) begin
         case ($urandom_range(0, 5))
            0: w = $urandom_range(0, 2);
            1: w = $urandom_range(9, 24);
            default: w = $urandom_range(3, 12);
         endcase
         h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 11);
         r = $urandom_range(0, 7);
         set_geometry(w, h, r);
         fast_send = ($urandom_range(0, 3) == 0);
         geometry(ew, eh, er);
         repeat ($urandom_range(1, 2)) begin
            send_frame(ew * eh, 1, 0);
            total += ew * eh;
         end
      end
      set_geometry(9, 9, 4);
      send_frame(81, 1, 0);

      wait_idle();
      if (mismatches == 0 && pixel_expect.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) items_sent++;
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               req_data <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each transfer, then pick the next stall
   int hold_left = 0;
   int pixels_seen = 0;
   bit long_hold_done = 0;
   always @(posedge clock) begin
      rsp_type want;
      int roll;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            pixels_seen++;
            if (pixel_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pixel %0d frame_end %0b",
                           rsp_data.filtered_pixel, rsp_data.frame_end);
            end else begin
               want = pixel_expect.pop_front();
               if (rsp_data.filtered_pixel !== want.filtered_pixel ||
                   rsp_data.frame_end !== want.frame_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pixel %0d: expected %0d/%0b got %0d/%0b", pixels_seen,
                              want.filtered_pixel, want.frame_end,
                              rsp_data.filtered_pixel, rsp_data.frame_end);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= (hold_left > 0);
         end else if (!long_hold_done && pixels_seen >= 150) begin
            long_hold_done = 1;
            hold_left = 2000;
            rsp_stall <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (fast_send || roll < 60) begin
               rsp_stall <= 1'b0;
            end else begin
               hold_left = (roll < 95) ? $urandom_range(1, 4) : $urandom_range(20, 300);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // watchdog
   initial begin
      #40000000;
      $display("FAIL");
      $finish;
   end

endmodule
